[rtl/pia_pkg.sv]
// pia_pkg: shared types and constants for the positional insert/erase array
// holds command and status codes plus the request and response word layouts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    // default number of list slots
    localparam int MAX_ENTRIES_DEF = 256;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_GET    = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [7:0]         index;
        logic signed [31:0] value;
        logic [8:0]         count;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [8:0]         length;
        logic [9:0]         capacity;
        status_t            status;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/pia_store.sv]
// pia_store: entry memory, one write port and one read port
// read data is registered and appears in the cycle after the read request
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module pia_store #(
    parameter int MAX_ENTRIES = 256,
    parameter int AW          = 8
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data
);

    logic [31:0] mem [MAX_ENTRIES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/pia_ctrl.sv]
// pia_ctrl: command sequencer for the positional insert/erase array
// checks ranges, grows the capacity figure, walks the memory to shift entries
// depends on pia_pkg; drives the pia_store ports
`timescale 1ns / 1ps
`default_nettype none

module pia_ctrl
    import pia_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int AW          = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire req_t          req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output rsp_t               rsp,
    output logic               rd_en,
    output logic      [AW-1:0] rd_addr,
    input  wire logic [31:0]   rd_data,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [31:0]   wr_data
);

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int WW    = ((CW > 9) ? CW : 9) + 1;
    localparam int CAP_W = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_SHIFT,
        S_PUT,
        S_ERASE,
        S_GET,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [WW-1:0]      idx_reg, idx_next;
    logic [WW-1:0]      need_reg, need_next;
    logic [WW-1:0]      n_reg, n_next;
    logic [WW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [31:0]        word_reg, word_next;
    logic [31:0]        rdv_reg, rdv_next;
    status_t            st_reg, st_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [WW-1:0] idx_in, cnt_in, cnt_cur, need_in, room, span, n_in, end_in;
    logic [WW-1:0] cap_w, rd_addr_w, wr_addr_w;

    assign idx_in  = WW'(req.index);
    assign cnt_in  = WW'(req.count);
    assign cnt_cur = WW'(count_reg);
    assign cap_w   = WW'(cap_reg);
    assign need_in = (cnt_in == '0) ? WW'(1) : cnt_in;
    assign room    = WW'(MAX_ENTRIES) - cnt_cur;
    assign span    = cnt_cur - idx_in;
    assign n_in    = (cnt_in < span) ? cnt_in : span;
    assign end_in  = idx_in + n_in;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        idx_next       = idx_reg;
        need_next      = need_reg;
        n_next         = n_reg;
        rd_ptr_next    = rd_ptr_reg;
        word_next      = word_reg;
        rdv_next       = rdv_reg;
        st_next        = st_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr_w      = rd_ptr_reg;
        wr_en          = 1'b0;
        wr_addr_w      = idx_reg;
        wr_data        = word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next  = idx_in;
                    word_next = req.value;
                    rdv_next  = '0;
                    st_next   = ST_DONE;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (idx_in > cnt_cur)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else if (need_in > room)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                need_next  = need_in;
                                state_next = S_GROW;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (idx_in >= cnt_cur)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else if (n_in == '0)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (end_in == cnt_cur)
                            begin
                                // tail erase, nothing to move
                                count_next = CW'(cnt_cur - n_in);
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                n_next      = n_in;
                                rd_en       = 1'b1;
                                rd_addr_w   = end_in;
                                rd_ptr_next = end_in;
                                state_next  = S_ERASE;
                            end
                        end
                        CMD_GET:
                        begin
                            if (idx_in >= cnt_cur)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr_w  = idx_in;
                                state_next = S_GET;
                            end
                        end
                        CMD_SET:
                        begin
                            if (idx_in >= cnt_cur)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr_w = idx_in;
                                wr_data   = req.value;
                            end
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_GROW:
            begin
                if (cnt_cur + need_reg >= cap_w)
                begin
                    cap_next = cap_reg << 1;
                end
                else if (idx_reg == cnt_cur)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr_w   = cnt_cur - WW'(1);
                    rd_ptr_next = cnt_cur - WW'(1);
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move the word read last cycle up one slot, then read the next lower one unless at the insert slot
                wr_en     = 1'b1;
                wr_addr_w = rd_ptr_reg + WW'(1);
                wr_data   = rd_data;
                if (rd_ptr_reg == idx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr_w   = rd_ptr_reg - WW'(1);
                    rd_ptr_next = rd_ptr_reg - WW'(1);
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr_w  = idx_reg;
                wr_data    = word_reg;
                count_next = CW'(cnt_cur + WW'(1));
                state_next = S_FINISH;
            end
            S_ERASE:
            begin
                // move the word read last cycle down by the erase run
                wr_en     = 1'b1;
                wr_addr_w = rd_ptr_reg - n_reg;
                wr_data   = rd_data;
                if (rd_ptr_reg == cnt_cur - WW'(1))
                begin
                    count_next = CW'(cnt_cur - n_reg);
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr_w   = rd_ptr_reg + WW'(1);
                    rd_ptr_next = rd_ptr_reg + WW'(1);
                end
            end
            S_GET:
            begin
                rdv_next   = rd_data;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_value = rdv_reg;
                    rsp_next.length     = cnt_cur[8:0];
                    rsp_next.capacity   = cap_w[9:0];
                    rsp_next.status     = st_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        need_reg   <= need_next;
        n_reg      <= n_next;
        rd_ptr_reg <= rd_ptr_next;
        word_reg   <= word_next;
        rdv_reg    <= rdv_next;
        st_reg     <= st_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_addr   = rd_addr_w[AW-1:0];
    assign wr_addr   = wr_addr_w[AW-1:0];

    // list length stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cur <= WW'(MAX_ENTRIES))
        else $error("entry count beyond store size");

    // capacity figure is always a power of two
    a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(cap_reg))
        else $error("capacity figure not a power of two");

    // between commands the capacity figure covers the list
    a_cap_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cap_w > cnt_cur))
        else $error("capacity figure does not exceed length");

    // erase moves always land below the word being read
    a_erase_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERASE) |-> (wr_addr_w < rd_ptr_reg && rd_ptr_reg < cnt_cur))
        else $error("erase move address out of order");

    // an item accepted in range for get reaches the read-capture state next
    a_get_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && req.cmd == CMD_GET && idx_in < cnt_cur)
        |=> (state_reg == S_GET))
        else $error("get did not issue a memory read");

endmodule

`default_nettype wire

[rtl/positional_insert_erase_array.sv]
// positional_insert_erase_array: top level of the ordered word list
// instantiates pia_ctrl (sequencer) and pia_store (entry memory)
// depends on pia_pkg
//
//   channel   | direction | word  | handshake
//   ----------+-----------+-------+------------------------------
//   request   | in        | req_t | req_valid / req_stall
//   response  | out       | rsp_t | rsp_valid / rsp_stall
//
// one command at a time; set, errors and tail erases need no memory walk, get
// reads the entry first, insert doubles capacity as needed, shifts the entries
// from index up one slot and writes the word, erase moves later entries down
// the shift loop moves one entry per cycle through the single memory port pair
// the next command is taken the cycle after the response is loaded, while the
// response may still sit stalled in its output register
// reset clears length to 0 and capacity to 1; memory contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_erase_array
    import pia_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    // memory address width
    localparam int AW = $clog2(MAX_ENTRIES);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // sequencer: range checks, capacity growth, shift walks
    pia_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // entry storage, registered read
    pia_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
